/* src/dcmm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dcmm_pkg
// Shared types, constants and the transition function for the drive
// command motor mixer.
// ----------------------------------------------------------------------------
package dcmm_pkg;

    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // motion state codes as seen on the output
    typedef enum logic [STATE_W-1:0] {
        MODE_STOP  = 4'd0,
        MODE_FWD   = 4'd1,
        MODE_BACK  = 4'd2,
        MODE_LEFT  = 4'd3,
        MODE_RIGHT = 4'd4,
        MODE_LF    = 4'd5,
        MODE_LB    = 4'd6,
        MODE_RF    = 4'd7,
        MODE_RB    = 4'd8
    } motion_mode_t;

    // command characters
    localparam logic [BYTE_W-1:0] CMD_STOP        = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_ADD_LEFT    = 8'h31;
    localparam logic [BYTE_W-1:0] CMD_ADD_RIGHT   = 8'h32;
    localparam logic [BYTE_W-1:0] CMD_ADD_FWD     = 8'h33;
    localparam logic [BYTE_W-1:0] CMD_ADD_BACK    = 8'h34;
    localparam logic [BYTE_W-1:0] CMD_CANCEL_LEFT  = 8'h35;
    localparam logic [BYTE_W-1:0] CMD_CANCEL_RIGHT = 8'h36;
    localparam logic [BYTE_W-1:0] CMD_CANCEL_FWD   = 8'h37;
    localparam logic [BYTE_W-1:0] CMD_CANCEL_BACK  = 8'h38;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEERING_SPEED = 2'd2;

    // reset speeds: 0.3, 0.35 and 0.8 of full scale
    localparam logic [SPEED_W-1:0] SLOW_SPEED_RST     = 16'd19660;
    localparam logic [SPEED_W-1:0] BASE_SPEED_RST     = 16'd22937;
    localparam logic [SPEED_W-1:0] STEERING_SPEED_RST = 16'd52428;

    function automatic motion_mode_t next_mode(input motion_mode_t m,
                                               input logic [BYTE_W-1:0] cmd);
        motion_mode_t n;
        n = m;
        case (cmd)
            CMD_STOP:      n = MODE_STOP;
            CMD_ADD_LEFT:  n = (m == MODE_FWD) ? MODE_LF :
                               ((m == MODE_BACK) ? MODE_LB : MODE_LEFT);
            CMD_ADD_RIGHT: n = (m == MODE_FWD) ? MODE_RF :
                               ((m == MODE_BACK) ? MODE_RB : MODE_RIGHT);
            CMD_ADD_FWD:   n = (m == MODE_LEFT) ? MODE_LF :
                               ((m == MODE_RIGHT) ? MODE_RF : MODE_FWD);
            CMD_ADD_BACK:  n = (m == MODE_LEFT) ? MODE_LB :
                               ((m == MODE_RIGHT) ? MODE_RB : MODE_BACK);
            CMD_CANCEL_LEFT:  n = (m == MODE_LF) ? MODE_FWD :
                                  ((m == MODE_LB) ? MODE_BACK : MODE_STOP);
            CMD_CANCEL_RIGHT: n = (m == MODE_RF) ? MODE_FWD :
                                  ((m == MODE_RB) ? MODE_BACK : MODE_STOP);
            CMD_CANCEL_FWD:   n = (m == MODE_LF) ? MODE_LEFT :
                                  ((m == MODE_RF) ? MODE_RIGHT : MODE_STOP);
            CMD_CANCEL_BACK:  n = (m == MODE_LB) ? MODE_LEFT :
                                  ((m == MODE_RB) ? MODE_RIGHT : MODE_STOP);
            default:       n = m;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

/* src/drive_command_motor_mixer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drive_command_motor_mixer_core
// Turns command bytes into a motion state and eight motor duty values.
// ----------------------------------------------------------------------------
// usage
//   input channel : in_valid / in_ready, one command byte per beat
//   output channel: out_valid / out_ready, motion state plus forward and
//                   reverse duty for four motors, one beat per input beat
//   config port   : cfg_write / cfg_index / cfg_data, writes take effect at
//                   the clock edge; index 0 slow, 1 base, 2 steering speed,
//                   index 3 is ignored; write only while the block is idle
// pipeline and throughput
//   a result passes the byte stage, which applies the transition, and then
//   the result register, which holds the duty select
//   one beat per cycle sustained while out_ready stays high
// reset
//   motion state returns to stop, speeds to their defaults, both stages empty
// stall
//   when out_ready is low the result register holds; the byte stage can
//   still take one more beat, after which in_ready drops until space frees
// ----------------------------------------------------------------------------
module drive_command_motor_mixer_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // command input
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [dcmm_pkg::BYTE_W-1:0]      received_byte,
    // result output
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [dcmm_pkg::STATE_W-1:0]          motion_state,
    output logic [dcmm_pkg::SPEED_W-1:0]          m1_fwd_duty,
    output logic [dcmm_pkg::SPEED_W-1:0]          m1_rev_duty,
    output logic [dcmm_pkg::SPEED_W-1:0]          m2_fwd_duty,
    output logic [dcmm_pkg::SPEED_W-1:0]          m2_rev_duty,
    output logic [dcmm_pkg::SPEED_W-1:0]          m3_fwd_duty,
    output logic [dcmm_pkg::SPEED_W-1:0]          m3_rev_duty,
    output logic [dcmm_pkg::SPEED_W-1:0]          m4_fwd_duty,
    output logic [dcmm_pkg::SPEED_W-1:0]          m4_rev_duty,
    // configuration
    input  wire logic                             cfg_write,
    input  wire logic [dcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dcmm_pkg::SPEED_W-1:0]     cfg_data
);

    localparam int unsigned SW = dcmm_pkg::SPEED_W;

    // speed registers
    logic [SW-1:0] slow_speed_reg;
    logic [SW-1:0] base_speed_reg;
    logic [SW-1:0] steering_speed_reg;

    // running motion state, advanced on every accepted byte
    dcmm_pkg::motion_mode_t mode_reg;
    dcmm_pkg::motion_mode_t mode_next;

    // byte stage: holds the state that the accepted byte produced
    logic                   s1_valid_reg;
    dcmm_pkg::motion_mode_t s1_mode_reg;

    // result register
    logic                   out_valid_reg;
    logic [dcmm_pkg::STATE_W-1:0] state_reg;
    logic [SW-1:0]          fwd12_reg;
    logic [SW-1:0]          rev12_reg;
    logic [SW-1:0]          fwd34_reg;
    logic [SW-1:0]          rev34_reg;

    logic          in_accept;
    logic          s1_advance;
    logic [SW-1:0] d12;
    logic [SW-1:0] d34;
    logic          f12;
    logic          f34;
    logic          drive_on;
    logic [SW-1:0] fwd12_next;
    logic [SW-1:0] rev12_next;
    logic [SW-1:0] fwd34_next;
    logic [SW-1:0] rev34_next;

    // handshake: result register frees when empty or taken
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // transition on the incoming byte; other bytes keep the state
    assign mode_next = dcmm_pkg::next_mode(mode_reg, received_byte);

    // speed registers, index 3 falls through untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_speed_reg     <= dcmm_pkg::SLOW_SPEED_RST;
            base_speed_reg     <= dcmm_pkg::BASE_SPEED_RST;
            steering_speed_reg <= dcmm_pkg::STEERING_SPEED_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dcmm_pkg::REG_SLOW_SPEED:     slow_speed_reg     <= cfg_data;
                dcmm_pkg::REG_BASE_SPEED:     base_speed_reg     <= cfg_data;
                dcmm_pkg::REG_STEERING_SPEED: steering_speed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // motion state and byte stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= dcmm_pkg::MODE_STOP;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                mode_reg <= mode_next;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg <= mode_next;
        end
    end

    // duty select: front pair (motors 1,2) and rear pair (motors 3,4)
    always_comb
    begin
        d12      = '0;
        d34      = '0;
        f12      = 1'b1;
        f34      = 1'b1;
        drive_on = 1'b1;
        case (s1_mode_reg)
            dcmm_pkg::MODE_FWD:
            begin
                d12 = base_speed_reg;  f12 = 1'b1;
                d34 = base_speed_reg;  f34 = 1'b1;
            end
            dcmm_pkg::MODE_BACK:
            begin
                d12 = base_speed_reg;  f12 = 1'b0;
                d34 = base_speed_reg;  f34 = 1'b0;
            end
            dcmm_pkg::MODE_LEFT:
            begin
                d12 = base_speed_reg;  f12 = 1'b1;
                d34 = base_speed_reg;  f34 = 1'b0;
            end
            dcmm_pkg::MODE_RIGHT:
            begin
                d12 = base_speed_reg;  f12 = 1'b0;
                d34 = base_speed_reg;  f34 = 1'b1;
            end
            dcmm_pkg::MODE_LF:
            begin
                d12 = steering_speed_reg; f12 = 1'b1;
                d34 = slow_speed_reg;     f34 = 1'b1;
            end
            dcmm_pkg::MODE_LB:
            begin
                d12 = slow_speed_reg;     f12 = 1'b0;
                d34 = steering_speed_reg; f34 = 1'b0;
            end
            dcmm_pkg::MODE_RF:
            begin
                d12 = slow_speed_reg;     f12 = 1'b1;
                d34 = steering_speed_reg; f34 = 1'b1;
            end
            dcmm_pkg::MODE_RB:
            begin
                d12 = steering_speed_reg; f12 = 1'b0;
                d34 = base_speed_reg;     f34 = 1'b0;
            end
            default:
            begin
                // stop and unused codes: all channels off
                drive_on = 1'b0;
            end
        endcase

        fwd12_next = (drive_on && f12)  ? d12 : '0;
        rev12_next = (drive_on && !f12) ? d12 : '0;
        fwd34_next = (drive_on && f34)  ? d34 : '0;
        rev34_next = (drive_on && !f34) ? d34 : '0;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            state_reg <= s1_mode_reg;
            fwd12_reg <= fwd12_next;
            rev12_reg <= rev12_next;
            fwd34_reg <= fwd34_next;
            rev34_reg <= rev34_next;
        end
    end

    // both motors of a pair share one duty
    assign out_valid    = out_valid_reg;
    assign motion_state = state_reg;
    assign m1_fwd_duty  = fwd12_reg;
    assign m1_rev_duty  = rev12_reg;
    assign m2_fwd_duty  = fwd12_reg;
    assign m2_rev_duty  = rev12_reg;
    assign m3_fwd_duty  = fwd34_reg;
    assign m3_rev_duty  = rev34_reg;
    assign m4_fwd_duty  = fwd34_reg;
    assign m4_rev_duty  = rev34_reg;

    // a stop byte always lands the state in stop
    a_stop_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && received_byte == dcmm_pkg::CMD_STOP)
        |=> (mode_reg == dcmm_pkg::MODE_STOP))
        else $error("stop command did not clear motion state");

    // no motor is driven both ways at once
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((fwd12_reg == '0 || rev12_reg == '0) &&
                           (fwd34_reg == '0 || rev34_reg == '0)))
        else $error("motor driven forward and reverse together");

    // stop state drives nothing
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && state_reg == dcmm_pkg::MODE_STOP)
        |-> (fwd12_reg == '0 && rev12_reg == '0 &&
             fwd34_reg == '0 && rev34_reg == '0))
        else $error("nonzero duty in stop state");

    // a held beat in the byte stage is never dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("byte stage lost a beat");

endmodule
`default_nettype wire
